[rtl/keyframe_pose_interpolator_assert.svh]
// ---------------------------------------------------------------------------
// Keyframe pose interpolator assertion macros
// Clocked assertion shorthands, all on aclk with reset masked.
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_POSE_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_POSE_INTERPOLATOR_ASSERT_SVH

// cond holds in the same cycle as trig
`define KPI_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// cond holds in the cycle after trig
`define KPI_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/kpi_pkg.sv]
// ---------------------------------------------------------------------------
// kpi_pkg
// Shared codes, controller states and the control/status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package kpi_pkg;

    typedef enum logic [1:0] {
        KIND_ADV  = 2'd0,
        KIND_RST  = 2'd1,
        KIND_LOAD = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_RDKEY,
        ST_KEYOUT,
        ST_ZERO,
        ST_DIV,
        ST_EASE1,
        ST_EASE2,
        ST_RDPREV,
        ST_RDCUR,
        ST_WAITO,
        ST_MUL,
        ST_ADD
    } state_t;

    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned NUM_COMP  = 6;

    typedef struct packed {
        logic       take_rst;
        logic       take_load;
        logic       take_adv;
        logic       rd_key;
        logic       step_walk;
        logic       div_init;
        logic       div_step;
        logic       ease1;
        logic       ease2;
        logic       rd_prev;
        logic       rd_cur;
        logic       lat_from;
        logic       mul;
        logic       add;
        logic       out_key;
        logic       out_zero;
        logic       out_done;
        logic       out_active;
        logic [3:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic trav_hit;
        logic hold_hit;
        logic k_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/kpi_ctrl.sv]
// ---------------------------------------------------------------------------
// kpi_ctrl
// Sequencer: item decode, schedule walk, divide, ease and blend steps.
// ---------------------------------------------------------------------------
`default_nettype none

module kpi_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [1:0]       kind,
    input  wire kpi_pkg::status_t sts,
    output kpi_pkg::cmd_t         cmd
);

    kpi_pkg::state_t state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            act_reg, act_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kpi_pkg::ST_IDLE;
            cnt_reg   <= '0;
            act_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            act_reg   <= act_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        act_next   = act_reg;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            kpi_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (kpi_pkg::kind_t'(kind))
                        kpi_pkg::KIND_ADV: begin
                            if (sts.n_zero) begin
                                state_next = kpi_pkg::ST_ZERO;
                            end else begin
                                cmd.take_adv = 1'b1;
                                state_next   = kpi_pkg::ST_RD;
                            end
                        end
                        kpi_pkg::KIND_RST:  cmd.take_rst  = 1'b1;
                        kpi_pkg::KIND_LOAD: cmd.take_load = 1'b1;
                        default: ;
                    endcase
                end
            end
            kpi_pkg::ST_RD: begin
                cmd.rd_key = 1'b1;
                state_next = kpi_pkg::ST_CHK;
            end
            kpi_pkg::ST_CHK: begin
                if (sts.trav_hit) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = kpi_pkg::ST_DIV;
                end else if (sts.hold_hit) begin
                    act_next   = 1'b1;
                    state_next = kpi_pkg::ST_RDKEY;
                end else begin
                    cmd.step_walk = 1'b1;
                    if (sts.k_last) begin
                        // past the end: last pose, inactive
                        act_next   = 1'b0;
                        state_next = kpi_pkg::ST_RDKEY;
                    end else begin
                        state_next = kpi_pkg::ST_RD;
                    end
                end
            end
            kpi_pkg::ST_RDKEY: begin
                cmd.rd_cur = 1'b1;
                state_next = kpi_pkg::ST_KEYOUT;
            end
            kpi_pkg::ST_KEYOUT: begin
                if (sts.out_free) begin
                    cmd.out_key    = 1'b1;
                    cmd.out_active = act_reg;
                    state_next     = kpi_pkg::ST_IDLE;
                end
            end
            kpi_pkg::ST_ZERO: begin
                if (sts.out_free) begin
                    cmd.out_zero = 1'b1;
                    state_next   = kpi_pkg::ST_IDLE;
                end
            end
            kpi_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'(kpi_pkg::DIV_STEPS - 1)) begin
                    state_next = kpi_pkg::ST_EASE1;
                end
            end
            kpi_pkg::ST_EASE1: begin
                cmd.ease1  = 1'b1;
                state_next = kpi_pkg::ST_EASE2;
            end
            kpi_pkg::ST_EASE2: begin
                cmd.ease2  = 1'b1;
                state_next = kpi_pkg::ST_RDPREV;
            end
            kpi_pkg::ST_RDPREV: begin
                cmd.rd_prev = 1'b1;
                state_next  = kpi_pkg::ST_RDCUR;
            end
            kpi_pkg::ST_RDCUR: begin
                cmd.lat_from = 1'b1;
                cmd.rd_cur   = 1'b1;
                state_next   = kpi_pkg::ST_WAITO;
            end
            kpi_pkg::ST_WAITO: begin
                // payload is rebuilt in place, so the old beat must be gone
                if (sts.out_free) begin
                    cnt_next   = '0;
                    state_next = kpi_pkg::ST_MUL;
                end
            end
            kpi_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = kpi_pkg::ST_ADD;
            end
            kpi_pkg::ST_ADD: begin
                cmd.add = 1'b1;
                if (cnt_reg == 4'(kpi_pkg::NUM_COMP - 1)) begin
                    cmd.out_done   = 1'b1;
                    cmd.out_active = 1'b1;
                    state_next     = kpi_pkg::ST_IDLE;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = kpi_pkg::ST_MUL;
                end
            end
            default: state_next = kpi_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/kpi_datapath.sv]
// ---------------------------------------------------------------------------
// kpi_datapath
// Keyframe memories, elapsed time, schedule cursor, divider, ease and blend.
// ---------------------------------------------------------------------------
`default_nettype none

module kpi_datapath #(
    parameter int MAX_KEYS = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire kpi_pkg::cmd_t  cmd,
    output kpi_pkg::status_t    sts,
    input  wire logic [295:0]   s_tdata,
    input  wire logic           cfg_valid,
    input  wire logic [4:0]     cfg_data,
    input  wire logic           m_tready,
    output logic                m_tvalid,
    output logic [191:0]        m_tdata,
    output logic [0:0]          m_tuser
);

    localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int CW = KW + 34;

    logic [191:0] pose_mem   [MAX_KEYS];
    logic [31:0]  travel_mem [MAX_KEYS];
    logic [31:0]  hold_mem   [MAX_KEYS];

    logic [4:0]          shot_count_reg;
    logic [31:0]         elapsed_reg;
    logic [NW-1:0]       k_reg;
    logic [CW-1:0]       cursor_reg;
    logic [31:0]         trav_rd_reg;
    logic [31:0]         hold_rd_reg;
    logic [191:0]        pose_rd_reg;
    logic [191:0]        from_reg;
    logic [31:0]         rem_reg;
    logic [15:0]         u_reg;
    logic [31:0]         uu_reg;
    logic [15:0]         s_reg;
    logic signed [49:0]  prod_reg;
    logic [191:0]        m_pose_reg;
    logic                m_valid_reg;
    logic                m_active_reg;

    // input fields
    logic [31:0] idx32;
    logic [31:0] in_travel, in_hold, in_delta;
    logic [KW-1:0] wr_idx;
    logic        idx_ok;

    assign idx32     = 32'(s_tdata[3:0]);
    assign wr_idx    = idx32[KW-1:0];
    assign idx_ok    = idx32 < 32'(MAX_KEYS);
    assign in_travel = s_tdata[227:196];
    assign in_hold   = s_tdata[259:228];
    assign in_delta  = s_tdata[291:260];

    // schedule walk
    logic [NW-1:0] n_lim;
    logic [NW-1:0] k_dec;
    logic [KW-1:0] k_idx, prev_idx;
    logic [31:0]   eff_trav;
    logic [CW-1:0] cur_t, cur_th, now_w;
    logic [32:0]   elapsed_sum;

    assign n_lim    = (32'(shot_count_reg) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS)
                                                             : NW'(shot_count_reg);
    assign k_dec    = k_reg - NW'(1);
    assign k_idx    = k_reg[KW-1:0];
    assign prev_idx = k_dec[KW-1:0];
    assign eff_trav = (k_reg == '0) ? 32'd0 : trav_rd_reg;
    assign now_w    = CW'(elapsed_reg);
    assign cur_t    = cursor_reg + CW'(eff_trav);
    assign cur_th   = cur_t + CW'(hold_rd_reg);
    assign elapsed_sum = {1'b0, elapsed_reg} + {1'b0, in_delta};

    assign sts.n_zero   = (n_lim == '0);
    assign sts.trav_hit = now_w < cur_t;
    assign sts.hold_hit = now_w < cur_th;
    assign sts.k_last   = (k_reg + NW'(1)) == n_lim;
    assign sts.out_free = !m_valid_reg || m_tready;

    // restoring divide step, one quotient bit per cycle
    logic [32:0] r2;
    logic [32:0] r2_sub;
    logic        q_bit;

    assign r2     = {rem_reg, 1'b0};
    assign r2_sub = r2 - {1'b0, trav_rd_reg};
    assign q_bit  = r2 >= {1'b0, trav_rd_reg};

    // ease: u*u*(3 - 2u) in Q0.16
    logic [17:0] ease_w;
    logic [49:0] ease_p;

    assign ease_w = 18'd196608 - {1'b0, u_reg, 1'b0};
    assign ease_p = {18'b0, uu_reg} * {32'b0, ease_w};

    // blend one component
    logic [7:0]         base;
    logic [31:0]        comp_a, comp_b;
    logic signed [32:0] comp_d;
    logic signed [49:0] blend_p;
    logic signed [49:0] blend_q;

    assign base    = {cmd.cnt[2:0], 5'b0};
    assign comp_a  = from_reg[base +: 32];
    assign comp_b  = pose_rd_reg[base +: 32];
    assign comp_d  = $signed({comp_b[31], comp_b}) - $signed({comp_a[31], comp_a});
    assign blend_p = 50'(comp_d) * 50'($signed({1'b0, s_reg}));
    assign blend_q = prod_reg >>> 16;   // floor toward minus infinity

    always_ff @(posedge aclk) begin
        if (cmd.take_load && idx_ok) begin
            pose_mem[wr_idx]   <= s_tdata[195:4];
            travel_mem[wr_idx] <= in_travel;
            hold_mem[wr_idx]   <= in_hold;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_key) begin
            trav_rd_reg <= travel_mem[k_idx];
            hold_rd_reg <= hold_mem[k_idx];
        end
        if (cmd.rd_prev) begin
            pose_rd_reg <= pose_mem[prev_idx];
        end else if (cmd.rd_cur) begin
            pose_rd_reg <= pose_mem[k_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shot_count_reg <= '0;
            elapsed_reg    <= '0;
            k_reg          <= '0;
            cursor_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                shot_count_reg <= cfg_data;
            end
            if (cmd.take_rst) begin
                elapsed_reg <= '0;
            end else if (cmd.take_adv) begin
                elapsed_reg <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
            end
            if (cmd.take_adv) begin
                k_reg      <= '0;
                cursor_reg <= '0;
            end else if (cmd.step_walk) begin
                cursor_reg <= cur_th;
                if (!sts.k_last) begin
                    k_reg <= k_reg + NW'(1);
                end
            end
            if (cmd.out_key || cmd.out_zero || cmd.out_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= 32'(now_w - cursor_reg);
            u_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? r2_sub[31:0] : r2[31:0];
            u_reg   <= {u_reg[14:0], q_bit};
        end
        if (cmd.ease1) begin
            uu_reg <= {16'b0, u_reg} * {16'b0, u_reg};
        end
        if (cmd.ease2) begin
            s_reg <= ease_p[47:32];
        end
        if (cmd.lat_from) begin
            from_reg <= pose_rd_reg;
        end
        if (cmd.mul) begin
            prod_reg <= blend_p;
        end
        if (cmd.add) begin
            m_pose_reg[base +: 32] <= comp_a + blend_q[31:0];
        end else if (cmd.out_key) begin
            m_pose_reg <= pose_rd_reg;
        end else if (cmd.out_zero) begin
            m_pose_reg <= '0;
        end
        if (cmd.out_key || cmd.out_zero || cmd.out_done) begin
            m_active_reg <= cmd.out_active;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pose_reg;
    assign m_tuser  = m_active_reg;

endmodule

`default_nettype wire

[rtl/keyframe_pose_interpolator.sv]
// Restart and load are taken in idle. An advance with no keyframes outputs a zero pose; else
//   it walks the keyframes (read, check), then at a hold or past the end outputs the key pose,
//   or in a travel phase runs divide, ease, previous and current pose reads, output wait and
//   blend. Output stalls hold it at the waits. Items are taken one at a time.
// Reset (aresetn low, synchronous) clears elapsed time, shot_count and output valid;
//   keyframe memories are not cleared.
// ---------------------------------------------------------------------------
// keyframe_pose_interpolator
// Smoothstep-eased keyframe pose playback in Q16.16 fixed point.
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyframe_pose_interpolator_assert.svh"

module keyframe_pose_interpolator #(
    parameter int MAX_KEYS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // shot_index[3:0], pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, travel_time,
    // hold_time, delta_time (32 b each from bit 4), zero pad [295:292]
    input  wire logic [295:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y, out_rot_z (32 b each)
    output logic [191:0]      m_tdata,
    // active
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [4:0]   cfg_data
);

    kpi_pkg::cmd_t    cmd;
    kpi_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    kpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    kpi_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    logic       adv_beat;
    logic       quick_beat;
    logic [2:0] out_loads;

    assign adv_beat   = s_tvalid && s_tready && (s_tuser == kpi_pkg::KIND_ADV);
    assign quick_beat = s_tvalid && s_tready &&
                        (s_tuser == kpi_pkg::KIND_RST || s_tuser == kpi_pkg::KIND_LOAD);
    assign out_loads  = {cmd.out_key, cmd.out_zero, cmd.out_done};

    `KPI_ASSERT_NEXT(a_adv_busy, adv_beat, !s_tready, "advance beat did not start work")
    `KPI_ASSERT_NEXT(a_quick_items, quick_beat, s_tready, "restart or load beat stalled input")
    `KPI_ASSERT_SAME(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "stray result beat")
    `KPI_ASSERT_SAME(a_cmd_exclusive, 1'b1, $onehot0(out_loads), "multiple result loads at once")

endmodule

`default_nettype wire
